/* rtl/core/npv_pkg.sv */
// shared types, codes and reserved namespace tables for the path validator
package npv_pkg;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        ST_VALID     = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_BAD_NS    = 3'd3,
        ST_BAD_CHAR  = 3'd4,
        ST_EMPTY_SEG = 3'd5,
        ST_DOT_SEG   = 3'd6
    } t_status;

    localparam int NAME_LEN_W = 8;
    localparam int PREFIX_W   = 4;
    localparam int SEG_W      = 2;
    localparam int NS_COUNT   = 5;
    localparam int NS_CAP     = 8;
    localparam int SEG_CAP    = 3;

    localparam t_byte CH_NUL   = 8'h00;
    localparam t_byte CH_COLON = 8'h3a;
    localparam t_byte CH_SLASH = 8'h2f;
    localparam t_byte CH_DOT   = 8'h2e;

    // reserved words, byte p of word i at bits [8p+7:8p]
    localparam logic [NS_COUNT-1:0][NS_CAP*8-1:0] NS_TEXT = {
        64'h0000_0000_0064_6f6d,
        64'h0000_656e_6967_6e65,
        64'h0064_6572_6572_6966,
        64'h0064_6c61_7265_6d65,
        64'h0000_0000_336e_6567
    };
    localparam logic [NS_COUNT-1:0][PREFIX_W-1:0] NS_LEN = {4'd3, 4'd6, 4'd7, 4'd7, 4'd4};

    // segment alphabet: a-z, 0-9, dot, underscore, dash
    function automatic logic seg_char(input t_byte c);
        seg_char = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h30 && c <= 8'h39)
                || c == CH_DOT || c == 8'h5f || c == 8'h2d;
    endfunction

endpackage

/* rtl/core/npv_char_if.sv */
// valid/ready channel carrying one name byte per word
interface npv_char_if;
    logic               valid;
    logic               ready;
    npv_pkg::t_byte     char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

/* rtl/core/npv_status_if.sv */
// valid/ready channel carrying one validation status per word
interface npv_status_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

/* rtl/core/namespaced_path_validator.sv */
// streaming validator for namespaced resource names, one byte per cycle, except that
// a terminating zero byte stalls while the result register holds an untaken status
// a zero byte's status passes the input register, then the result register; other
// bytes produce no word
// reset: synchronous active-low i_rst_n empties both registers and clears name state
module namespaced_path_validator #(
    parameter int MAX_NAME_LENGTH = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    npv_char_if.sink             i_char,
    npv_status_if.source         o_status
);

    localparam logic [npv_pkg::NAME_LEN_W-1:0] MAX_LEN = npv_pkg::NAME_LEN_W'(MAX_NAME_LENGTH);

    logic                                r_in_valid;
    npv_pkg::t_byte                      r_in_char;
    logic                                r_out_valid;
    npv_pkg::t_status                    r_out_status;

    logic                                r_in_path,        n_in_path;
    logic [npv_pkg::NAME_LEN_W-1:0]      r_name_length,    n_name_length;
    logic [npv_pkg::PREFIX_W-1:0]        r_prefix_length,  n_prefix_length;
    logic [npv_pkg::NS_COUNT-1:0]        r_match_mask,     n_match_mask;
    logic                                r_prefix_bad,     n_prefix_bad;
    logic                                r_prefix_error,   n_prefix_error;
    logic [npv_pkg::SEG_W-1:0]           r_seg_length,     n_seg_length;
    logic                                r_seg_all_dots,   n_seg_all_dots;
    npv_pkg::t_status                    r_first_err,      n_first_err;
    logic                                n_out_valid;
    npv_pkg::t_status                    n_out_status;

    logic                                w_out_free;
    logic                                w_consume;
    logic                                w_is_end;
    logic                                w_no_path;
    npv_pkg::t_status                    w_close;
    npv_pkg::t_status                    w_end_status;

    assign w_out_free   = !r_out_valid || o_status.ready;
    assign w_is_end     = (r_in_char == npv_pkg::CH_NUL);
    // zero byte needs a free result slot, other bytes always drain
    assign w_consume    = r_in_valid && (!w_is_end || w_out_free);
    assign i_char.ready = !r_in_valid || w_consume;

    assign o_status.valid  = r_out_valid;
    assign o_status.status = r_out_status;

    // colon was the last byte: nothing after it
    assign w_no_path = (r_prefix_length < npv_pkg::PREFIX_W'(npv_pkg::NS_CAP))
        && (r_name_length == npv_pkg::NAME_LEN_W'(r_prefix_length) + 8'd1);

    always_comb begin
        if (r_seg_length == '0) begin
            w_close = npv_pkg::ST_EMPTY_SEG;
        end else if (r_seg_all_dots && r_seg_length <= 2'd2) begin
            w_close = npv_pkg::ST_DOT_SEG;
        end else begin
            w_close = npv_pkg::ST_VALID;
        end
    end

    always_comb begin
        priority if (r_name_length == '0) begin
            w_end_status = npv_pkg::ST_EMPTY;
        end else if (r_name_length > MAX_LEN) begin
            w_end_status = npv_pkg::ST_TOO_LONG;
        end else if (!r_in_path || r_prefix_error || r_match_mask == '0 || w_no_path) begin
            w_end_status = npv_pkg::ST_BAD_NS;
        end else if (r_prefix_bad) begin
            w_end_status = npv_pkg::ST_BAD_CHAR;
        end else if (r_first_err != npv_pkg::ST_VALID) begin
            w_end_status = r_first_err;
        end else begin
            w_end_status = w_close;
        end
    end

    always_comb begin
        n_in_path       = r_in_path;
        n_name_length   = r_name_length;
        n_prefix_length = r_prefix_length;
        n_match_mask    = r_match_mask;
        n_prefix_bad    = r_prefix_bad;
        n_prefix_error  = r_prefix_error;
        n_seg_length    = r_seg_length;
        n_seg_all_dots  = r_seg_all_dots;
        n_first_err     = r_first_err;
        n_out_valid     = r_out_valid && !o_status.ready;
        n_out_status    = r_out_status;

        if (w_consume) begin
            if (w_is_end) begin
                n_out_valid     = 1'b1;
                n_out_status    = w_end_status;
                n_in_path       = 1'b0;
                n_name_length   = '0;
                n_prefix_length = '0;
                n_match_mask    = '1;
                n_prefix_bad    = 1'b0;
                n_prefix_error  = 1'b0;
                n_seg_length    = '0;
                n_seg_all_dots  = 1'b1;
                n_first_err     = npv_pkg::ST_VALID;
            end else begin
                if (r_name_length <= MAX_LEN) begin
                    n_name_length = r_name_length + 8'd1;
                end

                if (!r_in_path) begin
                    if (r_in_char == npv_pkg::CH_COLON) begin
                        n_in_path = 1'b1;
                        for (int i = 0; i < npv_pkg::NS_COUNT; i++) begin
                            if (r_prefix_length != npv_pkg::NS_LEN[i]) begin
                                n_match_mask[i] = 1'b0;
                            end
                        end
                    end else begin
                        if (!npv_pkg::seg_char(r_in_char)) begin
                            n_prefix_bad = 1'b1;
                        end
                        if (r_prefix_length < npv_pkg::PREFIX_W'(npv_pkg::NS_CAP)) begin
                            for (int i = 0; i < npv_pkg::NS_COUNT; i++) begin
                                if (r_prefix_length >= npv_pkg::NS_LEN[i]
                                    || npv_pkg::NS_TEXT[i][{r_prefix_length[2:0], 3'b000} +: 8]
                                       != r_in_char) begin
                                    n_match_mask[i] = 1'b0;
                                end
                            end
                            n_prefix_length = r_prefix_length + 4'd1;
                        end
                    end
                end else begin
                    if (r_in_char == npv_pkg::CH_COLON) begin
                        n_prefix_error = 1'b1;
                    end
                    if (r_in_char == npv_pkg::CH_SLASH) begin
                        if (r_first_err == npv_pkg::ST_VALID) begin
                            n_first_err = w_close;
                        end
                        n_seg_length   = '0;
                        n_seg_all_dots = 1'b1;
                    end else if (!npv_pkg::seg_char(r_in_char)) begin
                        if (r_first_err == npv_pkg::ST_VALID) begin
                            n_first_err = npv_pkg::ST_BAD_CHAR;
                        end
                    end else begin
                        if (r_seg_length < npv_pkg::SEG_W'(npv_pkg::SEG_CAP)) begin
                            n_seg_length = r_seg_length + 2'd1;
                        end
                        if (r_in_char != npv_pkg::CH_DOT) begin
                            n_seg_all_dots = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_code;
        end
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_in_path       <= 1'b0;
            r_name_length   <= '0;
            r_prefix_length <= '0;
            r_match_mask    <= '1;
            r_prefix_bad    <= 1'b0;
            r_prefix_error  <= 1'b0;
            r_seg_length    <= '0;
            r_seg_all_dots  <= 1'b1;
            r_first_err     <= npv_pkg::ST_VALID;
        end else begin
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            r_out_valid     <= n_out_valid;
            r_in_path       <= n_in_path;
            r_name_length   <= n_name_length;
            r_prefix_length <= n_prefix_length;
            r_match_mask    <= n_match_mask;
            r_prefix_bad    <= n_prefix_bad;
            r_prefix_error  <= n_prefix_error;
            r_seg_length    <= n_seg_length;
            r_seg_all_dots  <= n_seg_all_dots;
            r_first_err     <= n_first_err;
        end
    end

    // end of name always yields a result and restarts the name
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume && w_is_end |=> r_out_valid && r_name_length == '0 && !r_in_path)
        else $error("end of name did not produce a result or clear state");

    a_prefix_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prefix_length <= npv_pkg::PREFIX_W'(npv_pkg::NS_CAP))
        else $error("namespace length ran past its cap");

    a_path_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first_err == npv_pkg::ST_VALID || r_first_err == npv_pkg::ST_BAD_CHAR
        || r_first_err == npv_pkg::ST_EMPTY_SEG || r_first_err == npv_pkg::ST_DOT_SEG)
        else $error("recorded path error is not a path status");

    // path errors are only recorded once a colon was seen
    a_err_needs_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first_err != npv_pkg::ST_VALID |-> r_in_path)
        else $error("path error recorded before the namespace ended");

endmodule

/* tb/sv/npv_tb_pkg.sv */
// reserved namespace words and extra byte codes shared by the path validator testbench
`timescale 1ns / 1ps
package npv_tb_pkg;
    import npv_pkg::*;

    localparam t_byte CH_UNDER = 8'h5f;
    localparam t_byte CH_DASH  = 8'h2d;

    // reserved words, byte p of word i at bits [8p+7:8p]
    localparam logic [NS_COUNT-1:0][NS_CAP*8-1:0] WORD_TEXT = {
        64'h0000_0000_0064_6f6d,
        64'h0000_656e_6967_6e65,
        64'h0064_6572_6572_6966,
        64'h0064_6c61_7265_6d65,
        64'h0000_0000_336e_6567
    };
    localparam logic [NS_COUNT-1:0][PREFIX_W-1:0] WORD_LEN = {
        4'd3, 4'd6, 4'd7, 4'd7, 4'd4
    };

endpackage

/* tb/sv/npv_status_checker.sv */
// watches both channels, predicts each name status and compares it with the block output
`timescale 1ns / 1ps
module npv_status_checker
    import npv_pkg::*;
    import npv_tb_pkg::*;
#(
    parameter int MAX_NAME_LEN = 128
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    npv_char_if     i_char,
    npv_status_if   i_status,
    output int      o_fail_count,
    output int      o_pending
);

    typedef struct packed {
        logic                   in_path;
        logic [NAME_LEN_W-1:0]  name_len;
        logic [PREFIX_W-1:0]    ns_len;
        logic [NS_COUNT-1:0]    word_hits;
        logic                   ns_bad_byte;
        logic                   extra_colon;
        logic [SEG_W-1:0]       seg_len;
        logic                   seg_dots;
        t_status                path_err;
    } name_scan_t;

    name_scan_t scan;
    t_status    status_due[$];

    function automatic name_scan_t fresh_scan();
        name_scan_t s;
        s = '0;
        s.word_hits = '1;
        s.seg_dots = 1'b1;
        s.path_err = ST_VALID;
        return s;
    endfunction

    function automatic logic is_path_byte(t_byte c);
        return (c >= "a" && c <= "z") || (c >= "0" && c <= "9")
            || c == CH_DOT || c == CH_UNDER || c == CH_DASH;
    endfunction

    function automatic t_status seg_close(name_scan_t s);
        if (s.seg_len == 0)
            return ST_EMPTY_SEG;
        if (s.seg_dots && s.seg_len <= 2)
            return ST_DOT_SEG;
        return ST_VALID;
    endfunction

    function automatic name_scan_t next_scan(name_scan_t s, t_byte c);
        int p;
        if (s.name_len <= MAX_NAME_LEN)
            s.name_len++;
        if (!s.in_path) begin
            if (c == CH_COLON) begin
                s.in_path = 1'b1;
                for (int i = 0; i < NS_COUNT; i++)
                    if (s.ns_len != WORD_LEN[i])
                        s.word_hits[i] = 1'b0;
            end else begin
                if (!is_path_byte(c))
                    s.ns_bad_byte = 1'b1;
                if (s.ns_len < NS_CAP) begin
                    p = int'(s.ns_len);
                    for (int i = 0; i < NS_COUNT; i++)
                        if (p >= int'(WORD_LEN[i]) || WORD_TEXT[i][8*p +: 8] != c)
                            s.word_hits[i] = 1'b0;
                    s.ns_len++;
                end
            end
            return s;
        end
        if (c == CH_COLON)
            s.extra_colon = 1'b1;
        if (c == CH_SLASH) begin
            if (s.path_err == ST_VALID)
                s.path_err = seg_close(s);
            s.seg_len = '0;
            s.seg_dots = 1'b1;
        end else if (!is_path_byte(c)) begin
            if (s.path_err == ST_VALID)
                s.path_err = ST_BAD_CHAR;
        end else begin
            if (s.seg_len < SEG_CAP)
                s.seg_len++;
            if (c != CH_DOT)
                s.seg_dots = 1'b0;
        end
        return s;
    endfunction

    function automatic t_status end_status(name_scan_t s);
        if (s.name_len == 0)
            return ST_EMPTY;
        if (s.name_len > MAX_NAME_LEN)
            return ST_TOO_LONG;
        if (!s.in_path || s.extra_colon || s.word_hits == '0
                || (s.ns_len < NS_CAP && int'(s.name_len) == int'(s.ns_len) + 1))
            return ST_BAD_NS;
        if (s.ns_bad_byte)
            return ST_BAD_CHAR;
        if (s.path_err != ST_VALID)
            return s.path_err;
        return seg_close(s);
    endfunction

    always @(posedge i_clk) begin : track
        t_status want;
        if (!i_rst_n) begin
            scan = fresh_scan();
            status_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_status.valid && i_status.ready) begin
                if (status_due.size() == 0) begin
                    $error("status: no name pending, got %0d", i_status.status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = status_due.pop_front();
                    if (i_status.status !== want) begin
                        $error("status: expected %0d, got %0d", want, i_status.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_char.valid && i_char.ready) begin
                // a zero byte closes the name and starts the next one clean
                if (i_char.char_code == CH_NUL) begin
                    status_due.push_back(end_status(scan));
                    scan = fresh_scan();
                end else begin
                    scan = next_scan(scan, i_char.char_code);
                end
            end
        end
        o_pending <= status_due.size();
    end

endmodule

/* tb/sv/testbench.sv */
// top level: drives name bytes and status backpressure into the path validator, gives the verdict
`timescale 1ns / 1ps
module testbench;
    import npv_pkg::*;
    import npv_tb_pkg::*;

    localparam int MAX_NAME_LEN = 128;
    localparam int GAP_MAX      = 11;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 8;
    localparam int BYTE_TARGET  = 1300;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    npv_char_if   char_bus ();
    npv_status_if status_bus ();

    int     fail_count;
    int     pending;
    int     tx_gap_max = GAP_MAX;
    int     rx_gap_max = GAP_MAX;
    int     holds_asked = 0;
    int     holds_done = 0;
    int     bytes_sent = 0;
    int     names_sent = 0;
    int     quiet_cycles = 0;
    t_byte  name_buf[$];

    always #5 clk = ~clk;

    namespaced_path_validator #(
        .MAX_NAME_LENGTH(MAX_NAME_LEN)
    ) dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_char   (char_bus),
        .o_status (status_bus)
    );

    npv_status_checker #(
        .MAX_NAME_LEN(MAX_NAME_LEN)
    ) name_status_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_char       (char_bus),
        .i_status     (status_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if (!rst_n || (char_bus.valid && char_bus.ready)
                || (status_bus.valid && status_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // status receiver, one drawn pause per word, plus the long hold on request
    initial begin : status_rx
        int unsigned gap;
        status_bus.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (holds_asked > holds_done) begin
                holds_done++;
                gap = HOLD_CYCLES;
            end else begin
                gap = $urandom_range(0, rx_gap_max);
            end
            if (gap != 0) begin
                status_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            status_bus.ready <= 1'b1;
            do @(posedge clk); while (!status_bus.valid);
        end
    end

    task automatic send_byte(t_byte b);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0) begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_bus.valid <= 1'b1;
        char_bus.char_code <= b;
        @(posedge clk);
        while (!char_bus.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_name();
        foreach (name_buf[i])
            send_byte(name_buf[i]);
        send_byte(CH_NUL);
        name_buf.delete();
        names_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(t_byte'(s[i]));
        send_name();
    endtask

    // sender stops and waits until every status has come back
    task automatic wait_drained();
        char_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic t_byte pick_path_byte();
        case ($urandom_range(0, 7))
            0: return CH_DOT;
            1: return CH_UNDER;
            2: return CH_DASH;
            3: return t_byte'("0" + $urandom_range(0, 9));
            default: return t_byte'("a" + $urandom_range(0, 25));
        endcase
    endfunction

    function automatic t_byte pick_flaw_byte();
        case ($urandom_range(0, 3))
            0: return CH_SLASH;
            1: return CH_DOT;
            2: return CH_COLON;
            default: return t_byte'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic void push_word(int k);
        for (int p = 0; p < int'(WORD_LEN[k]); p++)
            name_buf.push_back(WORD_TEXT[k][8*p +: 8]);
    endfunction

    function automatic void push_path();
        int nseg;
        nseg = $urandom_range(1, 4);
        for (int s = 0; s < nseg; s++) begin
            if (s > 0)
                name_buf.push_back(CH_SLASH);
            case ($urandom_range(0, 9))
                0: ;
                1, 2: repeat ($urandom_range(1, 4)) name_buf.push_back(CH_DOT);
                default: repeat ($urandom_range(1, 5)) name_buf.push_back(pick_path_byte());
            endcase
        end
    endfunction

    function automatic void make_random_name();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind <= 10) begin
            // well-formed name, sometimes with one stray byte dropped in
            push_word($urandom_range(0, NS_COUNT - 1));
            name_buf.push_back(CH_COLON);
            push_path();
            if ($urandom_range(0, 3) == 0)
                name_buf.insert($urandom_range(0, name_buf.size()), pick_flaw_byte());
        end else if (kind <= 12) begin
            // namespace that almost matches a reserved word, or one of 8 to 10 random letters
            push_word($urandom_range(0, NS_COUNT - 1));
            case ($urandom_range(0, 3))
                0: name_buf[$urandom_range(0, name_buf.size() - 1)] = pick_path_byte();
                1: void'(name_buf.pop_back());
                2: name_buf.push_back(pick_path_byte());
                default: begin
                    name_buf.delete();
                    repeat ($urandom_range(8, 10))
                        name_buf.push_back(t_byte'("a" + $urandom_range(0, 25)));
                end
            endcase
            name_buf.push_back(CH_COLON);
            push_path();
        end else if (kind <= 14) begin
            repeat ($urandom_range(1, 12))
                name_buf.push_back(t_byte'($urandom_range(1, 255)));
        end else if (kind == 16) begin
            case ($urandom_range(0, 2))
                0: begin
                    name_buf.push_back(CH_COLON);
                    push_path();
                end
                1: begin
                    push_word($urandom_range(0, NS_COUNT - 1));
                    name_buf.push_back(CH_COLON);
                end
                default: push_word($urandom_range(0, NS_COUNT - 1));
            endcase
        end else if (kind >= 17) begin
            push_word($urandom_range(0, NS_COUNT - 1));
            name_buf.push_back(CH_COLON);
            repeat ($urandom_range(1, 8)) begin
                if (kind == 19)
                    name_buf.push_back(t_byte'($urandom_range(1, 255)));
                else
                    case ($urandom_range(0, 2))
                        0: name_buf.push_back(CH_DOT);
                        1: name_buf.push_back(CH_SLASH);
                        default: name_buf.push_back(t_byte'("a"));
                    endcase
            end
        end
        // kind 15 leaves the name empty
    endfunction

    task automatic send_random_until(int target);
        while (bytes_sent < target) begin
            make_random_name();
            send_name();
        end
    endtask

    task automatic send_long_name(int len);
        push_word(NS_COUNT - 1);
        name_buf.push_back(CH_COLON);
        while (name_buf.size() < len) begin
            if (name_buf.size() % 9 == 0 && name_buf.size() < len - 1)
                name_buf.push_back(CH_SLASH);
            else
                name_buf.push_back(t_byte'("a" + $urandom_range(0, 25)));
        end
        send_name();
    endtask

    initial begin
        char_bus.valid <= 1'b0;
        char_bus.char_code <= CH_NUL;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_text("");
        send_text("mod:a/b-c_9.z");
        send_text("a");
        send_text(":a");
        send_text("mod:");
        send_text("mod:a:b");
        send_text("abcdefgh:a");
        send_text("mod:A");
        send_text("mod:a//b");
        send_text("mod:.");
        name_buf.push_back(t_byte'("m"));
        name_buf.push_back(CH_COLON);
        name_buf.push_back(8'hff);
        send_name();

        send_random_until(300);

        // length limit: at the limit, one past it, and far past the saturation point
        send_long_name(MAX_NAME_LEN);
        send_long_name(MAX_NAME_LEN + 1);
        send_long_name(260);
        wait_drained();

        // output held off while the sender keeps pushing at full rate
        tx_gap_max = 0;
        holds_asked++;
        send_random_until(bytes_sent + 150);
        wait_drained();

        rx_gap_max = 0;
        send_random_until(bytes_sent + 150);
        tx_gap_max = GAP_MAX;
        rx_gap_max = GAP_MAX;
        send_random_until(BYTE_TARGET);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d bytes in %0d names: malformed and well-formed names,",
                 bytes_sent, names_sent);
        $display("length limits, a %0d-cycle output hold and drained pauses", HOLD_CYCLES);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/npv_pkg.sv
rtl/core/npv_char_if.sv
rtl/core/npv_status_if.sv
rtl/core/namespaced_path_validator.sv
tb/sv/npv_tb_pkg.sv
tb/sv/npv_status_checker.sv
tb/sv/testbench.sv
